FILE: rtl/multicamera_pixel_blend_assert.svh
`ifndef MULTICAMERA_PIXEL_BLEND_ASSERT_SVH
`define MULTICAMERA_PIXEL_BLEND_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MPB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MPB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/mpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpb_pkg;
    localparam int CAMERAS  = 4;
    localparam int NCAM     = 4;
    localparam int CH_W     = 12;
    localparam int WT_W     = 10;
    localparam int GAIN_W   = 10;
    localparam int LUMA_W   = 28;
    localparam int F_W      = 11;
    localparam int PRD_W    = CH_W + WT_W;
    localparam int SUM_W    = PRD_W + 2;
    localparam int SW_W     = WT_W + 2;
    localparam int FDIV_ST  = F_W;
    localparam int ODIV_ST  = CH_W;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 24;

    localparam logic [15:0] LUMA_KR = 16'd19595;
    localparam logic [15:0] LUMA_KG = 16'd38470;
    localparam logic [15:0] LUMA_KB = 16'd7471;
    localparam logic [CH_W-1:0] CH_MAX = 12'd4095;
    localparam logic [11:0] THR_MIN = 12'd16;

    localparam logic [IDX_W-1:0] CFG_GAIN0   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN1   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN2   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_GAIN3   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OCC_EN  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_OCC_THR = 3'd5;
    localparam logic [IDX_W-1:0] CFG_BG_RGB  = 3'd6;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic [WT_W-1:0] w;
    } t_cam;

    typedef struct packed {
        t_cam [NCAM-1:0]               cam;
        logic [NCAM-1:0]               ok;
        logic [NCAM-1:0]               drop;
        logic [NCAM-1:0]               fade;
        logic [NCAM-1:0][LUMA_W-1:0]   rem;
        logic [NCAM-1:0][F_W-1:0]      q;
    } t_fd;

    typedef struct packed {
        logic [2:0][CH_W-1:0] rem;
        logic [2:0][CH_W-1:0] low;
        logic [2:0][CH_W-1:0] q;
        logic [SW_W-1:0]      sw;
    } t_od;

    function automatic logic [CH_W-1:0] scale_sat(input logic [CH_W-1:0] c,
                                                  input logic [GAIN_W-1:0] g);
        logic [CH_W+GAIN_W:0] v;
        v = (CH_W+GAIN_W+1)'(c) * (CH_W+GAIN_W+1)'(g) + (CH_W+GAIN_W+1)'(128);
        if (v[CH_W+GAIN_W:8] > {3'b000, CH_MAX}) return CH_MAX;
        return v[CH_W+7:8];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/multicamera_pixel_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// Feathered blend of up to four camera samples per canvas pixel. One request per clock
// is accepted while o_in_ready is high, and its result is offered from a
// 31-stage pipeline; the depth is set by two restoring dividers that retire one quotient
// bit per stage (11 for the occlusion fade factor, 12 for the final weighted mean).
// Stalls on the output only hold the stages that are full, so bubbles collapse.
// Configuration writes take effect at once and are meant to be made while the pipeline
// is empty.
module multicamera_pixel_blend
    import mpb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire logic [3:0]        i_sample_valid,
    input  wire logic [45:0]       i_sample_cam0,
    input  wire logic [45:0]       i_sample_cam1,
    input  wire logic [45:0]       i_sample_cam2,
    input  wire logic [45:0]       i_sample_cam3,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      logic [CH_W-1:0]   o_out_red,
    output      logic [CH_W-1:0]   o_out_green,
    output      logic [CH_W-1:0]   o_out_blue,
    output      logic              o_covered
);
    localparam int S_SCL = 0;
    localparam int S_LUM = 1;
    localparam int S_BST = 2;
    localparam int S_DEF = 3;
    localparam int S_WGT = S_DEF + FDIV_ST + 1;
    localparam int S_PRD = S_WGT + 1;
    localparam int S_SUM = S_PRD + 1;
    localparam int S_OUT = S_SUM + ODIV_ST + 1;
    localparam int NST   = S_OUT + 1;

    logic [NCAM-1:0][GAIN_W-1:0] r_gain;
    logic                        r_occ_en;
    logic [11:0]                 r_occ_thr;
    logic [CFG_W-1:0]            r_bg;

    logic [NST-1:0] r_v;
    logic [NST-1:0] ce;

    t_cam [NCAM-1:0]             r_scl_cam;
    logic [NCAM-1:0]             r_scl_ok;
    t_cam [NCAM-1:0]             r_lum_cam;
    logic [NCAM-1:0]             r_lum_ok;
    logic [NCAM-1:0][LUMA_W-1:0] r_lum_l;
    t_cam [NCAM-1:0]             r_bst_cam;
    logic [NCAM-1:0]             r_bst_ok;
    logic [NCAM-1:0][LUMA_W-1:0] r_bst_l;
    logic [LUMA_W-1:0]           r_bst_best;
    t_fd                         r_fd [FDIV_ST+1];
    t_cam [NCAM-1:0]             r_wgt_cam;
    logic [NCAM-1:0][2:0][PRD_W-1:0] r_prd_p;
    logic [NCAM-1:0][WT_W-1:0]   r_prd_w;
    t_od                         r_od [ODIV_ST+1];
    logic [CH_W-1:0]             r_out_r, r_out_g, r_out_b;
    logic                        r_out_cov;

    logic [11:0]       thr_eff;
    logic [LUMA_W-1:0] tq;
    logic [45:0]       in_cam [NCAM];

    t_cam [NCAM-1:0]             n_scl_cam;
    logic [NCAM-1:0]             n_scl_ok;
    logic [NCAM-1:0][LUMA_W-1:0] n_lum_l;
    logic [LUMA_W-1:0]           n_best;
    t_fd                         n_fd [FDIV_ST+1];
    t_cam [NCAM-1:0]             n_wgt_cam;
    t_od                         n_od [ODIV_ST+1];

    assign thr_eff = (r_occ_thr < THR_MIN) ? THR_MIN : r_occ_thr;
    assign tq      = {thr_eff, 16'd0};
    assign in_cam[0] = i_sample_cam0;
    assign in_cam[1] = i_sample_cam1;
    assign in_cam[2] = i_sample_cam2;
    assign in_cam[3] = i_sample_cam3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCAM; k++) r_gain[k] <= GAIN_W'(256);
            r_occ_en  <= 1'b0;
            r_occ_thr <= THR_MIN;
            r_bg      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN0:   r_gain[0] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN1:   r_gain[1] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN2:   r_gain[2] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN3:   r_gain[3] <= i_cfg_data[GAIN_W-1:0];
                CFG_OCC_EN:  r_occ_en  <= i_cfg_data[0];
                CFG_OCC_THR: r_occ_thr <= i_cfg_data[11:0];
                CFG_BG_RGB:  r_bg      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ce[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST-2; k >= 0; k--) ce[k] = !r_v[k] || ce[k+1];
    end
    assign o_in_ready = ce[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ce[0]) r_v[0] <= i_in_valid;
            for (int k = 1; k < NST; k++) begin
                if (ce[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // gain and saturate
    always_comb begin
        for (int k = 0; k < NCAM; k++) begin
            n_scl_ok[k]    = (k < CAMERAS) && i_sample_valid[k];
            n_scl_cam[k].r = scale_sat(in_cam[k][45:34], r_gain[k]);
            n_scl_cam[k].g = scale_sat(in_cam[k][33:22], r_gain[k]);
            n_scl_cam[k].b = scale_sat(in_cam[k][21:10], r_gain[k]);
            n_scl_cam[k].w = in_cam[k][9:0];
        end
    end

    // luma
    always_comb begin
        for (int k = 0; k < NCAM; k++) begin
            n_lum_l[k] = LUMA_W'(LUMA_KR * r_scl_cam[k].r) + LUMA_W'(LUMA_KG * r_scl_cam[k].g)
                       + LUMA_W'(LUMA_KB * r_scl_cam[k].b);
        end
    end

    // brightest valid luma
    always_comb begin
        n_best = '0;
        for (int k = 0; k < NCAM; k++) begin
            if (r_lum_ok[k] && (r_lum_l[k] > n_best)) n_best = r_lum_l[k];
        end
    end

    // deficit, then one fade-factor quotient bit per stage
    always_comb begin
        logic [LUMA_W-1:0] d;
        logic [LUMA_W:0]   t;
        n_fd[0].cam  = r_bst_cam;
        n_fd[0].ok   = r_bst_ok;
        n_fd[0].q    = '0;
        for (int k = 0; k < NCAM; k++) begin
            d = r_bst_best - r_bst_l[k];
            n_fd[0].drop[k] = d > tq;
            n_fd[0].fade[k] = {d, 1'b0} > {1'b0, tq};
            n_fd[0].rem[k]  = n_fd[0].fade[k] ? (tq - d) : '0;
        end
        for (int j = 1; j <= FDIV_ST; j++) begin
            n_fd[j] = r_fd[j-1];
            for (int k = 0; k < NCAM; k++) begin
                t = {r_fd[j-1].rem[k], 1'b0};
                if (t >= {1'b0, tq}) begin
                    n_fd[j].rem[k] = LUMA_W'(t - {1'b0, tq});
                    n_fd[j].q[k]   = {r_fd[j-1].q[k][F_W-2:0], 1'b1};
                end else begin
                    n_fd[j].rem[k] = t[LUMA_W-1:0];
                    n_fd[j].q[k]   = {r_fd[j-1].q[k][F_W-2:0], 1'b0};
                end
            end
        end
    end

    // effective weight
    always_comb begin
        logic [WT_W+F_W-1:0] p;
        t_fd f;
        f = r_fd[FDIV_ST];
        for (int k = 0; k < NCAM; k++) begin
            p = f.cam[k].w * f.q[k];
            n_wgt_cam[k] = f.cam[k];
            if (!f.ok[k]) begin
                n_wgt_cam[k].w = '0;
            end else if (r_occ_en) begin
                if (f.drop[k]) n_wgt_cam[k].w = '0;
                else if (f.fade[k]) n_wgt_cam[k].w = (f.q[k] <= F_W'(1)) ? '0 : p[2*WT_W-1:WT_W];
            end
        end
    end

    // sums, then one mean quotient bit per stage
    always_comb begin
        logic [SUM_W-1:0] s [3];
        logic [SUM_W:0]   num;
        logic [CH_W:0]    t;
        for (int c = 0; c < 3; c++) s[c] = '0;
        n_od[0].sw = '0;
        for (int k = 0; k < NCAM; k++) begin
            for (int c = 0; c < 3; c++) s[c] = s[c] + SUM_W'(r_prd_p[k][c]);
            n_od[0].sw = n_od[0].sw + SW_W'(r_prd_w[k]);
        end
        for (int c = 0; c < 3; c++) begin
            num = {1'b0, s[c]} + (SUM_W+1)'(n_od[0].sw >> 1);
            n_od[0].rem[c] = num[2*CH_W-1:CH_W];
            n_od[0].low[c] = num[CH_W-1:0];
            n_od[0].q[c]   = '0;
        end
        for (int j = 1; j <= ODIV_ST; j++) begin
            n_od[j] = r_od[j-1];
            for (int c = 0; c < 3; c++) begin
                t = {r_od[j-1].rem[c], r_od[j-1].low[c][CH_W-1]};
                n_od[j].low[c] = {r_od[j-1].low[c][CH_W-2:0], 1'b0};
                if (t >= {1'b0, r_od[j-1].sw}) begin
                    n_od[j].rem[c] = CH_W'(t - {1'b0, r_od[j-1].sw});
                    n_od[j].q[c]   = {r_od[j-1].q[c][CH_W-2:0], 1'b1};
                end else begin
                    n_od[j].rem[c] = t[CH_W-1:0];
                    n_od[j].q[c]   = {r_od[j-1].q[c][CH_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[S_SCL]) begin
            r_scl_cam <= n_scl_cam;
            r_scl_ok  <= n_scl_ok;
        end
        if (ce[S_LUM]) begin
            r_lum_cam <= r_scl_cam;
            r_lum_ok  <= r_scl_ok;
            r_lum_l   <= n_lum_l;
        end
        if (ce[S_BST]) begin
            r_bst_cam  <= r_lum_cam;
            r_bst_ok   <= r_lum_ok;
            r_bst_l    <= r_lum_l;
            r_bst_best <= n_best;
        end
        for (int j = 0; j <= FDIV_ST; j++) begin
            if (ce[S_DEF+j]) r_fd[j] <= n_fd[j];
        end
        if (ce[S_WGT]) r_wgt_cam <= n_wgt_cam;
        if (ce[S_PRD]) begin
            for (int k = 0; k < NCAM; k++) begin
                r_prd_p[k][0] <= r_wgt_cam[k].r * r_wgt_cam[k].w;
                r_prd_p[k][1] <= r_wgt_cam[k].g * r_wgt_cam[k].w;
                r_prd_p[k][2] <= r_wgt_cam[k].b * r_wgt_cam[k].w;
                r_prd_w[k]    <= r_wgt_cam[k].w;
            end
        end
        for (int j = 0; j <= ODIV_ST; j++) begin
            if (ce[S_SUM+j]) r_od[j] <= n_od[j];
        end
        if (ce[S_OUT]) begin
            r_out_cov <= r_od[ODIV_ST].sw != '0;
            if (r_od[ODIV_ST].sw != '0) begin
                r_out_r <= r_od[ODIV_ST].q[0];
                r_out_g <= r_od[ODIV_ST].q[1];
                r_out_b <= r_od[ODIV_ST].q[2];
            end else begin
                r_out_r <= {r_bg[23:16], 4'd0};
                r_out_g <= {r_bg[15:8], 4'd0};
                r_out_b <= {r_bg[7:0], 4'd0};
            end
        end
    end

    assign o_out_valid = r_v[S_OUT];
    assign o_out_red   = r_out_r;
    assign o_out_green = r_out_g;
    assign o_out_blue  = r_out_b;
    assign o_covered   = r_out_cov;
endmodule
`default_nettype wire

FILE: rtl/mpb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "multicamera_pixel_blend_assert.svh"
module mpb_checker
    import mpb_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_cfg_we,
    input wire logic [IDX_W-1:0]  i_cfg_idx,
    input wire logic [CFG_W-1:0]  i_cfg_data,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic [3:0]        i_sample_valid,
    input wire logic [45:0]       i_sample_cam0,
    input wire logic [45:0]       i_sample_cam1,
    input wire logic [45:0]       i_sample_cam2,
    input wire logic [45:0]       i_sample_cam3,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [CH_W-1:0]   o_out_red,
    input wire logic [CH_W-1:0]   o_out_green,
    input wire logic [CH_W-1:0]   o_out_blue,
    input wire logic              o_covered
);
    `MPB_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_covered))
    `MPB_ASSERT_IMP(a_empty_ready, !o_out_valid, o_in_ready)
    `MPB_ASSERT_IMP(a_bg_fmt, o_out_valid && !o_covered, o_out_red[3:0] == 4'd0 && o_out_green[3:0] == 4'd0 && o_out_blue[3:0] == 4'd0)
    `MPB_ASSERT_IMP(a_reset_empty, $past(!i_rst_n), !o_out_valid)
endmodule

bind multicamera_pixel_blend mpb_checker u_mpb_checker (.*);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            cov;
    } pixel_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [3:0]        i_sample_valid = '0;
    logic [45:0]       i_sample_cam0 = '0;
    logic [45:0]       i_sample_cam1 = '0;
    logic [45:0]       i_sample_cam2 = '0;
    logic [45:0]       i_sample_cam3 = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [CH_W-1:0]   o_out_red;
    logic [CH_W-1:0]   o_out_green;
    logic [CH_W-1:0]   o_out_blue;
    logic              o_covered;

    multicamera_pixel_blend dut (.*);

    always #5 i_clk = ~i_clk;

    logic [GAIN_W-1:0] gain_cfg [NCAM];
    logic              occ_en_cfg;
    logic [11:0]       occ_thr_cfg;
    logic [23:0]       bg_cfg;

    pixel_t pending_pixels [$];
    int     mismatches = 0;
    int     requests_sent = 0;
    int     pixels_checked = 0;
    int     covered_seen = 0;
    int     background_seen = 0;
    int     idle_cycles = 0;
    bit     steady = 1'b0;

    function automatic logic [45:0] pack_sample(int r, int g, int b, int w);
        return {r[11:0], g[11:0], b[11:0], w[9:0]};
    endfunction

    function automatic longint unsigned scale_channel(longint unsigned c, longint unsigned g);
        longint unsigned v;
        v = (c * g + 128) >> 8;
        return (v > 4095) ? 4095 : v;
    endfunction

    function automatic pixel_t blend_pixel(logic [3:0] vld, logic [45:0] cam [NCAM]);
        longint unsigned rc [NCAM], gc [NCAM], bc [NCAM], wc [NCAM], lc [NCAM];
        longint unsigned best, tq, d, f, w, sr, sg, sb, sw, v;
        bit              any;
        pixel_t          px;
        best = 0; any = 0; sr = 0; sg = 0; sb = 0; sw = 0;
        for (int k = 0; k < NCAM; k++) begin
            rc[k] = scale_channel(cam[k][45:34], gain_cfg[k]);
            gc[k] = scale_channel(cam[k][33:22], gain_cfg[k]);
            bc[k] = scale_channel(cam[k][21:10], gain_cfg[k]);
            wc[k] = cam[k][9:0];
            lc[k] = 19595 * rc[k] + 38470 * gc[k] + 7471 * bc[k];
            if (k < CAMERAS && vld[k] && (!any || lc[k] > best)) begin
                best = lc[k];
                any = 1;
            end
        end
        tq = longint'((occ_thr_cfg < 16) ? 16 : occ_thr_cfg) << 16;
        for (int k = 0; k < NCAM; k++) begin
            w = wc[k];
            if (!(k < CAMERAS && vld[k])) continue;
            if (occ_en_cfg) begin
                d = best - lc[k];
                if (d > tq) continue;
                if (2 * d > tq) begin
                    f = (2048 * (tq - d)) / tq;
                    if (f <= 1) continue;
                    w = (w * f) >> 10;
                end
            end
            sr += rc[k] * w;
            sg += gc[k] * w;
            sb += bc[k] * w;
            sw += w;
        end
        if (sw > 0) begin
            v = (sr + sw / 2) / sw; px.r = (v > 4095) ? 12'd4095 : v[11:0];
            v = (sg + sw / 2) / sw; px.g = (v > 4095) ? 12'd4095 : v[11:0];
            v = (sb + sw / 2) / sw; px.b = (v > 4095) ? 12'd4095 : v[11:0];
            px.cov = 1'b1;
        end else begin
            px.r = {bg_cfg[23:16], 4'h0};
            px.g = {bg_cfg[15:8], 4'h0};
            px.b = {bg_cfg[7:0], 4'h0};
            px.cov = 1'b0;
        end
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic send_pixel(input logic [3:0] vld, input logic [45:0] c0,
                              input logic [45:0] c1, input logic [45:0] c2,
                              input logic [45:0] c3);
        logic [45:0] cams [NCAM];
        int          gap;
        if (!steady && $urandom_range(0, 99) < 29) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_valid <= vld;
        i_sample_cam0  <= c0;
        i_sample_cam1  <= c1;
        i_sample_cam2  <= c2;
        i_sample_cam3  <= c3;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cams = '{c0, c1, c2, c3};
        pending_pixels.insert(pending_pixels.size(), blend_pixel(vld, cams));
        requests_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input int data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= IDX_W'(idx);
        i_cfg_data <= CFG_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN0, CFG_GAIN1, CFG_GAIN2, CFG_GAIN3: gain_cfg[idx] = data[GAIN_W-1:0];
            CFG_OCC_EN:  occ_en_cfg = data[0];
            CFG_OCC_THR: occ_thr_cfg = data[11:0];
            CFG_BG_RGB:  bg_cfg = data[23:0];
            default: ;
        endcase
    endtask

    task automatic set_all_gains(input int g);
        write_reg(CFG_GAIN0, g);
        write_reg(CFG_GAIN1, g);
        write_reg(CFG_GAIN2, g);
        write_reg(CFG_GAIN3, g);
    endtask

    function automatic logic [45:0] random_sample();
        return 46'({$urandom, $urandom});
    endfunction

    function automatic logic [45:0] near_sample(int r, int g, int b);
        int spread;
        spread = 2 * ((occ_thr_cfg < 16) ? 16 : occ_thr_cfg);
        r = r - $urandom_range(0, spread); if (r < 0) r = 0;
        g = g - $urandom_range(0, spread); if (g < 0) g = 0;
        b = b - $urandom_range(0, spread); if (b < 0) b = 0;
        return pack_sample(r, g, b, $urandom_range(0, 1023));
    endfunction

    task automatic test_defaults();
        send_pixel(4'h0, '0, '0, '0, '0);
        send_pixel(4'hF, pack_sample(4095, 4095, 4095, 1023), pack_sample(0, 0, 0, 1023),
                   pack_sample(4095, 0, 4095, 1), pack_sample(0, 4095, 0, 0));
        send_pixel(4'h1, pack_sample(4095, 4095, 4095, 0), random_sample(),
                   random_sample(), random_sample());
        send_pixel(4'h8, '0, '0, '0, pack_sample(123, 2000, 4000, 1023));
        send_pixel(4'h6, 46'h3FFF_FFFF_FFFF, 46'h3FFF_FFFF_FFFF, 46'h3FFF_FFFF_FFFF,
                   46'h3FFF_FFFF_FFFF);
    endtask

    task automatic test_gains();
        write_reg(CFG_GAIN0, 0);
        write_reg(CFG_GAIN1, 1023);
        write_reg(CFG_GAIN2, 1);
        write_reg(CFG_GAIN3, 512);
        send_pixel(4'hF, pack_sample(4095, 4095, 4095, 1023), pack_sample(4095, 4095, 4095, 1023),
                   pack_sample(4095, 100, 1, 1023), pack_sample(3000, 2048, 2047, 500));
        send_pixel(4'h2, '0, pack_sample(1000, 1001, 1002, 7), '0, '0);
        send_pixel(4'h1, pack_sample(4095, 4095, 4095, 1023), '0, '0, '0);
        set_all_gains(256);
    endtask

    task automatic test_background();
        write_reg(CFG_BG_RGB, 24'hFFFFFF);
        send_pixel(4'h0, random_sample(), random_sample(), random_sample(), random_sample());
        send_pixel(4'hF, pack_sample(10, 20, 30, 0), pack_sample(1, 2, 3, 0),
                   pack_sample(4095, 4095, 4095, 0), pack_sample(0, 0, 0, 0));
        write_reg(CFG_BG_RGB, 24'h12A5C3);
        send_pixel(4'h0, '0, '0, '0, '0);
    endtask

    task automatic test_occlusion();
        write_reg(CFG_OCC_EN, 1);
        write_reg(CFG_OCC_THR, 16);
        // gray samples: deficit in whole Q8.4 steps against a 1.0 threshold
        send_pixel(4'hF, pack_sample(1000, 1000, 1000, 1023), pack_sample(995, 995, 995, 1023),
                   pack_sample(985, 985, 985, 800), pack_sample(984, 984, 984, 1023));
        send_pixel(4'hF, pack_sample(500, 500, 500, 0), pack_sample(483, 483, 483, 1023),
                   pack_sample(491, 491, 491, 1023), pack_sample(492, 492, 492, 1023));
        send_pixel(4'h3, pack_sample(2000, 2000, 2000, 0), pack_sample(10, 10, 10, 1023), '0, '0);
        write_reg(CFG_OCC_THR, 4095);
        // tiny fade factors near the far edge of a full-scale band
        send_pixel(4'hF, pack_sample(4095, 4095, 4095, 1), pack_sample(0, 0, 20, 1023),
                   pack_sample(0, 0, 40, 1023), pack_sample(10, 0, 0, 1023));
        send_pixel(4'h3, pack_sample(4095, 4095, 4095, 0), pack_sample(0, 0, 0, 1023), '0, '0);
        send_pixel(4'hF, pack_sample(4095, 4095, 4095, 1023), pack_sample(4095, 4095, 4095, 1023),
                   pack_sample(2048, 2048, 2048, 1023), pack_sample(2047, 2047, 2047, 1023));
        write_reg(CFG_OCC_EN, 0);
    endtask

    task automatic test_random();
        int          r, g, b, gn;
        logic [45:0] c [NCAM];
        for (int phase = 0; phase < 8; phase++) begin
            for (int k = 0; k < NCAM; k++) begin
                case ($urandom_range(0, 3))
                    0: gn = 256;
                    1: gn = 0;
                    2: gn = 1023;
                    default: gn = $urandom_range(0, 1023);
                endcase
                write_reg(k, gn);
            end
            write_reg(CFG_OCC_EN, phase % 3 != 0);
            case (phase % 4)
                0: write_reg(CFG_OCC_THR, 16);
                1: write_reg(CFG_OCC_THR, 4095);
                default: write_reg(CFG_OCC_THR, $urandom_range(16, 600));
            endcase
            write_reg(CFG_BG_RGB, $urandom_range(0, 24'hFFFFFF));
            steady = (phase == 5);
            for (int n = 0; n < 135; n++) begin
                if ($urandom_range(0, 99) < 65) begin
                    r = $urandom_range(0, 4095);
                    g = $urandom_range(0, 4095);
                    b = $urandom_range(0, 4095);
                    for (int k = 0; k < NCAM; k++) c[k] = near_sample(r, g, b);
                end else begin
                    for (int k = 0; k < NCAM; k++) c[k] = random_sample();
                end
                send_pixel(4'($urandom_range(0, 15)), c[0], c[1], c[2], c[3]);
                if (phase == 2 && n == 60) wait_idle();
            end
            steady = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (o_covered) covered_seen++; else background_seen++;
                if (o_out_red !== want.r)
                    report_mismatch($sformatf("red %0d, want %0d", o_out_red, want.r));
                if (o_out_green !== want.g)
                    report_mismatch($sformatf("green %0d, want %0d", o_out_green, want.g));
                if (o_out_blue !== want.b)
                    report_mismatch($sformatf("blue %0d, want %0d", o_out_blue, want.b));
                if (o_covered !== want.cov)
                    report_mismatch($sformatf("covered %0b, want %0b", o_covered, want.cov));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int k = 0; k < NCAM; k++) gain_cfg[k] = 10'd256;
        occ_en_cfg  = 1'b0;
        occ_thr_cfg = 12'd16;
        bg_cfg      = 24'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_gains();
        test_background();
        test_occlusion();
        test_random();
        wait_idle();
        $display("Sent %0d pixels, checked %0d (%0d covered, %0d background)",
                 requests_sent, pixels_checked, covered_seen, background_seen);
        $display("Swept gains, occlusion on/off, thresholds 1.0 to max, fades and drops");
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: multicamera_pixel_blend.f
+incdir+rtl
rtl/mpb_pkg.sv
rtl/multicamera_pixel_blend.sv
rtl/mpb_checker.sv
verif/testbench.sv
